// ----- src/lmsd_pkg.sv -----
`default_nettype none
package lmsd_pkg;

  // Default number of logical rows (stacked 8x8 panels times eight)
  localparam int ROWS_DEF = 16;

  // Rows scanned per panel and the base of the scan period
  localparam int       PANEL_ROWS  = 8;
  localparam logic [8:0] PERIOD_BASE = 9'd264;

  // Physical column position of each logical column bit
  localparam logic [2:0] COL_PERM [8] = '{3'd5, 3'd0, 3'd2, 3'd3, 3'd1, 3'd4, 3'd6, 3'd7};
  // Row drive bit for each scanned row
  localparam logic [2:0] ROW_PERM [8] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_PIXEL   = 2'd1,
    MODE_ROW     = 2'd2,
    MODE_PRESENT = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_BLANK,
    S_SCAN_RD,
    S_SCAN_OUT,
    S_PIX_RD,
    S_PIX_WR,
    S_CPY_RD,
    S_CPY_WR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture the incoming word
    logic row_wr;      // write a whole row into the pending buffer
    logic swap;        // exchange shown and pending buffers
    logic tick;        // advance the scan counter
    logic scan_rd;     // read the shown row for the current panel
    logic pix_rd;      // read the pending row for a pixel update
    logic pix_wr;      // write the updated pending row
    logic cpy_rd;      // read one shown row for the copy
    logic cpy_wr;      // write it to the pending buffer
    logic load_scan;   // put a column byte into the output register
    logic load_blank;  // put a blank strobe into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  row_ok;
    logic  take;
    logic  blank;
    logic  scan_final;
    logic  copy_final;
    logic  out_free;
  } sts_t;

  // Move logical column bits to their physical positions
  function automatic logic [7:0] perm_cols(input logic [7:0] v);
    logic [7:0] o;
    o = '0;
    for (int i = 0; i < 8; i++) begin
      o[COL_PERM[i]] = v[i];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- src/lmsd_ctrl.sv -----
`default_nettype none
module lmsd_ctrl import lmsd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (sts.mode)
            MODE_TICK:    state_nxt = S_TICK;
            MODE_PIXEL:   state_nxt = sts.row_ok ? S_PIX_RD : S_IDLE;
            MODE_ROW:     state_nxt = S_IDLE;
            MODE_PRESENT: state_nxt = sts.take ? S_CPY_RD : S_IDLE;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK:     state_nxt = sts.blank ? S_BLANK : S_SCAN_RD;
      S_BLANK:    if (sts.out_free) state_nxt = S_IDLE;
      S_SCAN_RD:  state_nxt = S_SCAN_OUT;
      S_SCAN_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.scan_final ? S_IDLE : S_SCAN_RD;
        end
      end
      S_PIX_RD:   state_nxt = S_PIX_WR;
      S_PIX_WR:   state_nxt = S_IDLE;
      S_CPY_RD:   state_nxt = S_CPY_WR;
      S_CPY_WR:   state_nxt = sts.copy_final ? S_IDLE : S_CPY_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch  = 1'b1;
          cmd.row_wr = (sts.mode == MODE_ROW) && sts.row_ok;
          cmd.swap   = (sts.mode == MODE_PRESENT);
        end
      end
      S_TICK:     cmd.tick       = 1'b1;
      S_BLANK:    cmd.load_blank = sts.out_free;
      S_SCAN_RD:  cmd.scan_rd    = 1'b1;
      S_SCAN_OUT: cmd.load_scan  = sts.out_free;
      S_PIX_RD:   cmd.pix_rd     = 1'b1;
      S_PIX_WR:   cmd.pix_wr     = 1'b1;
      S_CPY_RD:   cmd.cpy_rd     = 1'b1;
      S_CPY_WR:   cmd.cpy_wr     = 1'b1;
      default:    cmd            = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/lmsd_dp.sv -----
`default_nettype none
module lmsd_dp import lmsd_pkg::*; #(
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_tuser,
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire cmd_t        cmd,
  output sts_t             sts
);

  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;

  // Incoming word fields
  logic [3:0] in_row;
  logic [2:0] in_col;
  logic [7:0] in_wdata;
  logic       in_take;
  assign in_row   = in_tdata[3:0];
  assign in_col   = in_tdata[6:4];
  assign in_wdata = in_tdata[14:7];
  assign in_take  = in_tdata[15];

  // Control registers
  logic             shown_r;
  logic [8:0]       scan_count_r;
  logic [7:0]       bright_r;
  logic [DEPTH-1:0] vld_r;
  logic             out_vld_r;

  // Payload registers
  logic [RW-1:0] item_row_r;
  logic [2:0]    item_col_r;
  logic          item_bit_r;
  logic [RW-1:0] scan_row_r;
  logic [RW-1:0] cpy_idx_r;
  logic [7:0]    drive_r;
  logic [7:0]    mem_q_r;
  logic          vld_q_r;
  logic [7:0]    out_byte_r;
  logic          out_sv_r;
  logic [7:0]    out_drive_r;
  logic          out_last_r;

  logic [7:0] mem [0:DEPTH-1];

  // Scan count decision
  logic [9:0] cnt;
  logic [8:0] period;
  logic       cnt_hi;
  logic       wrap;
  logic [2:0] scan_first;
  assign cnt        = {1'b0, scan_count_r} + 10'd1;
  assign period     = PERIOD_BASE - {1'b0, bright_r};
  assign cnt_hi     = (cnt >= 10'(PANEL_ROWS));
  assign wrap       = cnt_hi && (cnt >= {1'b0, period});
  assign scan_first = wrap ? 3'd0 : cnt[2:0];

  // Status; the final panel is the last whole group of eight rows
  logic scan_final;
  logic out_free;
  assign scan_final     = int'(scan_row_r) >= (ROWS / PANEL_ROWS - 1) * PANEL_ROWS;
  assign out_free       = !out_vld_r || out_tready;
  assign sts.mode       = mode_t'(in_tuser);
  assign sts.row_ok     = int'(in_row) < ROWS;
  assign sts.take       = in_take;
  assign sts.blank      = cnt_hi && !wrap;
  assign sts.scan_final = scan_final;
  assign sts.copy_final = (cpy_idx_r == RW'(ROWS - 1));
  assign sts.out_free   = out_free;

  // Read data, zero where never written
  logic [7:0] rd_byte;
  assign rd_byte = vld_q_r ? mem_q_r : 8'd0;

  // Memory port selection
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    pix_mask;

  assign pix_mask = 8'd1 << COL_PERM[item_col_r];

  always_comb begin
    wr_en   = cmd.row_wr || cmd.pix_wr || cmd.cpy_wr;
    wr_addr = {~shown_r, item_row_r};
    wr_data = rd_byte;
    if (cmd.row_wr) begin
      wr_addr = {~shown_r, RW'(in_row)};
      wr_data = perm_cols(in_wdata);
    end else if (cmd.pix_wr) begin
      wr_data = item_bit_r ? (rd_byte | pix_mask) : (rd_byte & ~pix_mask);
    end else if (cmd.cpy_wr) begin
      wr_addr = {~shown_r, cpy_idx_r};
    end
  end

  always_comb begin
    rd_en   = cmd.scan_rd || cmd.pix_rd || cmd.cpy_rd;
    rd_addr = {shown_r, scan_row_r};
    if (cmd.pix_rd) begin
      rd_addr = {~shown_r, item_row_r};
    end else if (cmd.cpy_rd) begin
      rd_addr = {shown_r, cpy_idx_r};
    end
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // Control state: buffers, scan count, brightness, valid bits, output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r      <= 1'b0;
      scan_count_r <= '0;
      bright_r     <= 8'd255;
      vld_r        <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        bright_r <= cfg_wdata;
      end
      if (cmd.swap) begin
        shown_r <= ~shown_r;
      end
      if (cmd.tick) begin
        scan_count_r <= wrap ? 9'd0 : cnt[8:0];
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.load_scan || cmd.load_blank) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Item fields, scan and copy pointers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_row_r <= RW'(in_row);
      item_col_r <= in_col;
      item_bit_r <= in_wdata[0];
    end
    if (cmd.swap) begin
      cpy_idx_r <= '0;
    end else if (cmd.cpy_wr) begin
      cpy_idx_r <= cpy_idx_r + 1'b1;
    end
    if (cmd.tick) begin
      scan_row_r <= RW'(scan_first);
      drive_r    <= 8'd1 << ROW_PERM[scan_first];
    end else if (cmd.load_scan && !scan_final) begin
      scan_row_r <= RW'(int'(scan_row_r) + PANEL_ROWS);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_scan) begin
      out_byte_r  <= ~rd_byte;
      out_sv_r    <= 1'b1;
      out_drive_r <= scan_final ? drive_r : 8'd0;
      out_last_r  <= scan_final;
    end else if (cmd.load_blank) begin
      out_byte_r  <= 8'd0;
      out_sv_r    <= 1'b0;
      out_drive_r <= 8'd0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_drive_r, out_sv_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ----- src/led_matrix_scan_double_buffer.sv -----
// Double-buffered scanner for a multiplexed matrix of stacked 8x8 panels.
// Input stream: tuser selects the word kind (scan tick, set pixel, set row,
// present). A scan tick yields ROWS/8 output words: one inverted column
// byte per panel, the last one with tlast and the one-hot row drive. Ticks
// past row 7 yield one blank word (tlast only) until the period of
// 264 - brightness ticks ends. Writes and present yield no output.
// Each input word is handled by the controller walking the frame store: a
// scan tick reads and loads each panel's row in turn, a blank tick loads
// one blank word, a pixel write reads then writes the pending row, row
// write and present act as the word is taken, and a copy moves every row.
// The last output word sits in the output register while the next input
// word is taken; when out_tready is low the scan waits before loading the
// next byte and no input is taken until the tick is done.
// Reset: both buffers read as zero, buffer 0 shown, scan count 0 (the first
// tick scans row 1), brightness 255. cfg_we writes brightness.
`default_nettype none
module led_matrix_scan_double_buffer import lmsd_pkg::*; #(
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // row_index[3:0], pixel_column[6:4], write_data[14:7], copy_shown[15]
  input  wire logic [15:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // shift_byte[7:0], shift_valid[8], row_drive[16:9], zero[23:17]
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  lmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lmsd_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import lmsd_pkg::*;

  localparam int NROWS       = 16;
  localparam int NPANELS     = NROWS / 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 48;   // covers a present with copy
  localparam int PHASE_WORDS = 125;

  // Physical bit of each logical column
  localparam int COL_POS [8] = '{5, 0, 2, 3, 1, 4, 6, 7};

  localparam int IDLE_PCT  [4] = '{0, 74, 0, 21};
  localparam int STALL_PCT [4] = '{0, 0, 74, 21};
  localparam logic [7:0] PHASE_BRIGHT [4] = '{8'd254, 8'd128, 8'd0, 8'd247};

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SCAN,
    CHK_BLANK
  } chk_src_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] row;
    logic [2:0] col;
    logic [7:0] data;
    logic       take;
  } matrix_word_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       shift_valid;
    logic [7:0] row_drive;
    logic       last;
  } panel_word_t;

  typedef struct packed {
    matrix_word_t w;
    chk_src_t     src;
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [7:0]   drive;
  } dir_row_t;

  // Directed words: typed results only for plain reset-state and blank ticks
  localparam int NDIR = 25;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_SCAN,  8'hFF, 8'hFF, 8'h40},
    '{'{MODE_ROW,     4'd1,  3'd0, 8'hFF, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_ROW,     4'd9,  3'd7, 8'h00, 1'b1}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_ROW,     4'd9,  3'd0, 8'h01, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PIXEL,   4'd0,  3'd0, 8'h01, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PIXEL,   4'd15, 3'd7, 8'hFF, 1'b1}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PIXEL,   4'd8,  3'd4, 8'h01, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PIXEL,   4'd8,  3'd4, 8'hFE, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd15, 3'd7, 8'hFF, 1'b1}, CHK_SCAN,  8'hFF, 8'hFF, 8'h20},
    '{'{MODE_PRESENT, 4'd0,  3'd0, 8'h00, 1'b1}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_BLANK, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_ROW,     4'd1,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PRESENT, 4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PIXEL,   4'd15, 3'd7, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_PRESENT, 4'd15, 3'd7, 8'hFF, 1'b1}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_TICK,    4'd0,  3'd0, 8'h00, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00},
    '{'{MODE_ROW,     4'd15, 3'd0, 8'hAA, 1'b0}, CHK_MODEL, 8'h00, 8'h00, 8'h00}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  // Shadow of the block: both frame buffers, shown select, scan count, brightness
  logic [7:0] frame_buf [2][NROWS];
  logic       shown_buf;
  logic [8:0] scan_cnt;
  logic [7:0] bright;

  panel_word_t scan_out_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_err     = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_cfg     = 0;
  int cyc       = 0;

  always #1 clk = ~clk;

  led_matrix_scan_double_buffer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Apply one input word to the shadow state; queue the scan words it causes
  function automatic int matrix_step(input matrix_word_t w);
    int         nxt;
    int         period;
    logic       old;
    logic [7:0] permuted;
    panel_word_t pw;
    case (w.mode)
      MODE_TICK: begin
        nxt    = int'(scan_cnt) + 1;
        period = 264 - int'(bright);
        if (nxt >= 8 && nxt < period) begin
          scan_cnt = 9'(nxt);
          pw = '{8'h00, 1'b0, 8'h00, 1'b1};
          scan_out_q.push_back(pw);
          return 1;
        end
        if (nxt >= 8) nxt = 0;
        scan_cnt = 9'(nxt);
        for (int k = 0; k < NPANELS; k++) begin
          pw.shift_byte  = ~frame_buf[shown_buf][nxt + 8 * k];
          pw.shift_valid = 1'b1;
          pw.last        = (k == NPANELS - 1);
          pw.row_drive   = pw.last ? 8'(1 << (7 - nxt)) : 8'h00;
          scan_out_q.push_back(pw);
        end
        return NPANELS;
      end
      MODE_PIXEL: begin
        // row_index is 4 bits and ROWS is 16, so every row is in range
        frame_buf[!shown_buf][w.row][COL_POS[w.col]] = w.data[0];
      end
      MODE_ROW: begin
        permuted = '0;
        for (int i = 0; i < 8; i++) permuted[COL_POS[i]] = w.data[i];
        frame_buf[!shown_buf][w.row] = permuted;
      end
      default: begin
        old       = shown_buf;
        shown_buf = !old;
        if (w.take) begin
          for (int i = 0; i < NROWS; i++) frame_buf[old][i] = frame_buf[!old][i];
        end
      end
    endcase
    return 0;
  endfunction

  function automatic matrix_word_t rand_word(input int tick_pct);
    matrix_word_t w;
    int r;
    r = $urandom_range(99);
    if (r < tick_pct) w.mode = MODE_TICK;
    else if (r < tick_pct + (100 - tick_pct) * 45 / 100) w.mode = MODE_PIXEL;
    else if (r < tick_pct + (100 - tick_pct) * 80 / 100) w.mode = MODE_ROW;
    else w.mode = MODE_PRESENT;
    w.row  = 4'($urandom_range(15));
    w.col  = 3'($urandom_range(7));
    w.data = 8'($urandom_range(255));
    w.take = 1'($urandom_range(1));
    return w;
  endfunction

  // Offer one word, hold it until taken, then update the shadow state
  task automatic send_word(input matrix_word_t w, input chk_src_t src,
                           input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] drv);
    int n;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.mode;
    in_tdata  <= {w.take, w.data, w.col, w.row};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    n = matrix_step(w);
    // Replace the computed words with the hand-written ones where given
    if (src != CHK_MODEL) begin
      repeat (n) void'(scan_out_q.pop_back());
      if (src == CHK_SCAN) begin
        scan_out_q.push_back('{b0, 1'b1, 8'h00, 1'b0});
        scan_out_q.push_back('{b1, 1'b1, drv, 1'b1});
      end else begin
        scan_out_q.push_back('{8'h00, 1'b0, 8'h00, 1'b1});
      end
    end
  endtask

  // Drop valid, wait for every queued word, then let a copy finish
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (scan_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bright = v;
    n_cfg++;
  endtask

  // Check each accepted output word against the oldest queued one
  always @(posedge clk) begin
    panel_word_t got;
    panel_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[8], out_tdata[16:9], out_tlast};
      if (scan_out_q.size() == 0) begin
        $error("unexpected word: shift_byte %h row_drive %h last %b",
               got.shift_byte, got.row_drive, got.last);
        n_err++;
      end else begin
        want = scan_out_q.pop_front();
        n_checked++;
        if (got.shift_byte !== want.shift_byte) begin
          $error("shift_byte: expected %h, got %h", want.shift_byte, got.shift_byte);
          n_err++;
        end
        if (got.shift_valid !== want.shift_valid) begin
          $error("shift_valid: expected %b, got %b", want.shift_valid, got.shift_valid);
          n_err++;
        end
        if (got.row_drive !== want.row_drive) begin
          $error("row_drive: expected %h, got %h", want.row_drive, got.row_drive);
          n_err++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, got.last);
          n_err++;
        end
      end
    end
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still queued", cyc, scan_out_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int i;
    for (int b = 0; b < 2; b++) begin
      for (int r = 0; r < NROWS; r++) frame_buf[b][r] = '0;
    end
    shown_buf = 1'b0;
    scan_cnt  = '0;
    bright    = 8'd255;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset brightness (period 9)
    for (int d = 0; d < NDIR; d++) begin
      send_word(DIR_TAB[d].w, DIR_TAB[d].src, DIR_TAB[d].b0, DIR_TAB[d].b1,
                DIR_TAB[d].drive);
    end
    wait_drained();

    // Longest period: run past its wrap, then shorten it below the count
    idle_pct  = 21;
    stall_pct = 21;
    set_brightness(8'd0);
    i = 0;
    while (i < 300 || scan_cnt < 9'd20) begin
      send_word(rand_word(100), CHK_MODEL, 8'h00, 8'h00, 8'h00);
      i++;
    end
    wait_drained();
    set_brightness(8'd255);
    for (int t = 0; t < 4; t++) send_word(rand_word(100), CHK_MODEL, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Random phases, one per idle/stall mix
    for (int p = 0; p < 4; p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      set_brightness((p == 2) ? 8'($urandom_range(255)) : PHASE_BRIGHT[p]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        send_word(rand_word(45), CHK_MODEL, 8'h00, 8'h00, 8'h00);
      end
      wait_drained();
    end

    $display("covered %0d input words (%0d directed) and %0d checked output words",
             n_sent, NDIR, n_checked);
    $display("brightness written %0d times, period 9 through 264, four idle/stall mixes",
             n_cfg);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
